// ----- src/local_mean_classify_cluster_top_macros.svh -----
// Assertion helpers shared by the queue and back modules of the local mean classifier.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef LOCAL_MEAN_CLASSIFY_CLUSTER_TOP_MACROS_SVH
`define LOCAL_MEAN_CLASSIFY_CLUSTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lmcc_pkg.sv -----
`timescale 1ns / 1ps

package lmcc_pkg;

  // Position flags that travel with every sample from the front to the back.
  typedef struct packed {
    logic first;  // first sample of the frame
    logic win;    // a full 3x3 window ends here
    logic clu;    // a 2x2 cluster can be judged here
    logic last;   // last sample of the frame
  } pos_flags_t;

  localparam int FLAGS_W = 4;

  // Class and cluster codes.
  localparam logic [1:0] CODE_BELOW = 2'd0;
  localparam logic [1:0] CODE_EQUAL = 2'd1;
  localparam logic [1:0] CODE_ABOVE = 2'd2;
  localparam logic [1:0] CODE_NONE  = 2'd3;

  // Register indexes (address bit 2 of the configuration port).
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  localparam int         CFG_W     = 7;
  localparam logic [6:0] DIM_RESET = 7'd20;
  localparam int         DIM_MIN   = 3;

  localparam int WINDOW_CELLS  = 9;
  localparam int ZERO_SUM_MEAN = -2 * 10000;

  // Remainder thresholds of the corrected division by nine.
  localparam logic [4:0] REM_ROUND_ONE = 5'd5;
  localparam logic [4:0] REM_ROUND_TWO = 5'd14;

  localparam int          COUNT_W   = 12;
  localparam logic [11:0] COUNT_MAX = 12'hFFF;
  localparam int          TALLY_N   = 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

endpackage

// ----- src/lmcc_front.sv -----
`timescale 1ns / 1ps

module lmcc_front #(
  parameter int MAX_DIM     = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   restart,
  input  logic [6:0]                             grid_rows,
  input  logic [6:0]                             grid_cols,
  input  logic                                   sample_valid,
  input  logic signed [SAMPLE_BITS-1:0]          sample,
  output logic                                   sample_stall,
  input  logic                                   full,
  output logic                                   push,
  output logic signed [SAMPLE_BITS+3:0]          win_sum,
  output logic signed [SAMPLE_BITS-1:0]          centre,
  output logic [$clog2(MAX_DIM)-1:0]             col_out,
  output lmcc_pkg::pos_flags_t                   flags_out
);

  localparam int PW = $clog2(MAX_DIM);
  localparam int CW = SAMPLE_BITS + 2;
  localparam int SW = SAMPLE_BITS + 4;

  function automatic logic [PW-1:0] last_index(input logic [6:0] v);
    logic [PW-1:0] r;
    if (32'(v) < 32'(lmcc_pkg::DIM_MIN)) begin
      r = PW'(lmcc_pkg::DIM_MIN - 1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = PW'(MAX_DIM - 1);
    end else begin
      r = PW'(32'(v) - 32'd1);
    end
    return r;
  endfunction

  logic signed [SAMPLE_BITS-1:0] upper_mem [MAX_DIM];
  logic signed [SAMPLE_BITS-1:0] middle_mem [MAX_DIM];

  logic [PW-1:0] row, col, row_last, col_last;
  logic          fen, accept;
  lmcc_pkg::pos_flags_t flags_now;

  logic                          f1_valid;
  logic signed [SAMPLE_BITS-1:0] f1_top, f1_mid, f1_sample;
  logic [PW-1:0]                 f1_col;
  lmcc_pkg::pos_flags_t          f1_flags;
  logic signed [CW-1:0]          colsum;

  logic                          f2_valid;
  logic signed [CW-1:0]          f2_colsum, f2_prev1, f2_prev2;
  logic signed [SAMPLE_BITS-1:0] f2_centre;
  logic [PW-1:0]                 f2_col;
  lmcc_pkg::pos_flags_t          f2_flags;

  logic signed [CW-1:0]          hist_sum1, hist_sum2;
  logic signed [SAMPLE_BITS-1:0] hist_mid;

  assign row_last = last_index(grid_rows);
  assign col_last = last_index(grid_cols);

  // The whole front advances together; it only holds when the queue is full.
  assign fen          = !full;
  assign sample_stall = full;
  assign accept       = sample_valid && fen;

  always_comb begin
    flags_now.first = (row == '0) && (col == '0);
    flags_now.win   = (row >= PW'(2)) && (col >= PW'(2));
    flags_now.clu   = (row >= PW'(3)) && (col >= PW'(3));
    flags_now.last  = (col >= col_last) && (row >= row_last);
  end

  assign colsum = CW'(f1_top) + CW'(f1_mid) + CW'(f1_sample);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row       <= '0;
      col       <= '0;
      f1_valid  <= 1'b0;
      f2_valid  <= 1'b0;
      hist_sum1 <= '0;
      hist_sum2 <= '0;
      hist_mid  <= '0;
    end else if (fen) begin
      f1_valid <= sample_valid;
      f2_valid <= f1_valid;
      if (accept) begin
        if (col >= col_last) begin
          col <= '0;
          row <= (row >= row_last) ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (f1_valid) begin
        hist_sum2 <= hist_sum1;
        hist_sum1 <= colsum;
        hist_mid  <= f1_mid;
      end
    end
  end

  // Line stores: read as the sample enters, written back once it moves on.
  // The next read of the same column is at least three samples later.
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_top <= upper_mem[col];
      f1_mid <= middle_mem[col];
    end
    if (fen && f1_valid) begin
      upper_mem[f1_col]  <= f1_mid;
      middle_mem[f1_col] <= f1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_sample <= sample;
      f1_col    <= col;
      f1_flags  <= flags_now;
      f2_colsum <= colsum;
      f2_prev1  <= hist_sum1;
      f2_prev2  <= hist_sum2;
      f2_centre <= hist_mid;
      f2_col    <= f1_col;
      f2_flags  <= f1_flags;
    end
  end

  assign push      = fen && f2_valid;
  assign win_sum   = SW'(f2_colsum) + SW'(f2_prev1) + SW'(f2_prev2);
  assign centre    = f2_centre;
  assign col_out   = f2_col;
  assign flags_out = f2_flags;

endmodule

// ----- src/lmcc_fifo.sv -----
`timescale 1ns / 1ps
`include "local_mean_classify_cluster_top_macros.svh"

module lmcc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = lmcc_pkg::QUEUE_PTR_W;
  localparam int CNT_W = lmcc_pkg::QUEUE_CNT_W;

  logic [WIDTH-1:0] slots [lmcc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(lmcc_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  `LMCC_ASSERT_NOW(a_push_not_full, push, !full, "queue written while full")
  `LMCC_ASSERT_NOW(a_pop_not_empty, pop, !empty, "queue read while empty")
  `LMCC_ASSERT_NEXT(a_count_grows, push && !pop, count == $past(count) + 3'd1, "queue count slipped")

endmodule

// ----- src/lmcc_back.sv -----
`timescale 1ns / 1ps
`include "local_mean_classify_cluster_top_macros.svh"

module lmcc_back #(
  parameter int MAX_DIM     = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic                              q_valid,
  input  logic signed [SAMPLE_BITS+3:0]     q_sum,
  input  logic signed [SAMPLE_BITS-1:0]     q_centre,
  input  logic [$clog2(MAX_DIM)-1:0]        q_col,
  input  lmcc_pkg::pos_flags_t              q_flags,
  output logic                              pop,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              class_valid,
  output logic [1:0]                        class_code,
  output logic signed [SAMPLE_BITS-1:0]     local_mean,
  output logic                              cluster_valid,
  output logic [1:0]                        cluster_code,
  output logic                              frame_end,
  output logic [lmcc_pkg::COUNT_W-1:0]      class_below_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      class_equal_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      class_above_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      cluster_below_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      cluster_equal_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      cluster_above_count
);

  localparam int PW     = $clog2(MAX_DIM);
  localparam int SW     = SAMPLE_BITS + 4;
  localparam int MW     = SAMPLE_BITS + 3;
  localparam int PRODW  = 2 * MW;
  localparam int MNW    = (SAMPLE_BITS + 1 > 16) ? SAMPLE_BITS + 1 : 16;
  localparam int FW     = lmcc_pkg::FLAGS_W;
  localparam int SIDE_W = SAMPLE_BITS + PW + FW + 2;
  localparam int STAGES = 6;
  localparam int CNTW   = lmcc_pkg::COUNT_W;
  // floor(2^MW / 9); the quotient it gives is at most one short.
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << MW) / 64'(lmcc_pkg::WINDOW_CELLS));

  logic                ben;
  logic [STAGES:1]     vld;
  logic [SIDE_W-1:0]   side [1:STAGES];

  logic                sum_neg, sum_zero;
  logic [MW-1:0]       mag_in;
  logic [MW-1:0]       mag1;
  logic [PRODW-1:0]    prod2;
  logic [4:0]          mag5_2;
  logic [MW-1:0]       qa;
  logic [4:0]          qa9;
  logic [MW-1:0]       qa3;
  logic [4:0]          rem3;
  logic [1:0]          round_inc;
  logic [MW-1:0]       qr4;
  logic signed [MNW-1:0] qr_s;
  logic signed [MNW-1:0] mean5;
  logic signed [MNW-1:0] centre_ext;
  logic [1:0]          cls6;
  logic signed [SAMPLE_BITS-1:0] mean6;
  logic [1:0]          up_right;
  logic [1:0]          cls_mem [MAX_DIM];

  logic                neg4, zero4;
  logic signed [SAMPLE_BITS-1:0] centre5;
  logic [PW-1:0]       col5, col6;
  lmcc_pkg::pos_flags_t flags6;

  logic [1:0]          nb_up, nb_left;
  logic                match;
  logic [CNTW-1:0]     tally      [lmcc_pkg::TALLY_N];
  logic [CNTW-1:0]     tally_next [lmcc_pkg::TALLY_N];
  logic [CNTW-1:0]     count_q    [lmcc_pkg::TALLY_N];
  logic [lmcc_pkg::TALLY_N-1:0] bump;

  // The back moves as one pipeline whenever the output register can take a result.
  assign ben = !result_valid || !result_stall;
  assign pop = ben && q_valid;

  assign sum_neg  = q_sum[SW-1];
  assign sum_zero = (q_sum == '0);
  assign mag_in   = sum_neg ? MW'(-q_sum) : MW'(q_sum);

  assign neg4    = side[4][1];
  assign zero4   = side[4][0];
  assign centre5 = side[5][SIDE_W-1 -: SAMPLE_BITS];
  assign col5    = side[5][PW+FW+1 -: PW];
  assign col6    = side[6][PW+FW+1 -: PW];
  assign flags6  = lmcc_pkg::pos_flags_t'(side[6][FW+1:2]);

  assign qa  = prod2[PRODW-1:MW];
  // Only the low bits of 9*qa matter: the true remainder is below eighteen.
  assign qa9 = {qa[1:0], 3'b000} + qa[4:0];

  always_comb begin
    if (rem3 >= lmcc_pkg::REM_ROUND_TWO) begin
      round_inc = 2'd2;
    end else if (rem3 >= lmcc_pkg::REM_ROUND_ONE) begin
      round_inc = 2'd1;
    end else begin
      round_inc = 2'd0;
    end
  end

  assign qr_s       = MNW'(qr4);
  assign centre_ext = MNW'(centre5);

  assign match = (nb_up == cls6) && (up_right == cls6) && (nb_left == cls6);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bump[k]     = flags6.win && (cls6 == 2'(k));
      bump[k + 3] = flags6.clu && match && (cls6 == 2'(k));
    end
    for (int k = 0; k < lmcc_pkg::TALLY_N; k++) begin
      tally_next[k] = flags6.first ? '0 : tally[k];
      if (bump[k] && (tally_next[k] != lmcc_pkg::COUNT_MAX)) begin
        tally_next[k] = tally_next[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
      nb_up        <= lmcc_pkg::CODE_BELOW;
      nb_left      <= lmcc_pkg::CODE_BELOW;
      for (int k = 0; k < lmcc_pkg::TALLY_N; k++) begin
        tally[k] <= '0;
      end
    end else if (restart) begin
      nb_up   <= lmcc_pkg::CODE_BELOW;
      nb_left <= lmcc_pkg::CODE_BELOW;
      for (int k = 0; k < lmcc_pkg::TALLY_N; k++) begin
        tally[k] <= '0;
      end
    end else if (ben) begin
      vld          <= {vld[STAGES-1:1], pop};
      result_valid <= vld[STAGES];
      if (vld[STAGES]) begin
        tally <= tally_next;
        if (flags6.win) begin
          nb_up   <= up_right;
          nb_left <= cls6;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      side[1] <= {q_centre, q_col, q_flags, sum_neg, sum_zero};
      for (int k = 2; k <= STAGES; k++) begin
        side[k] <= side[k-1];
      end
      mag1   <= mag_in;
      prod2  <= PRODW'(mag1) * PRODW'(RECIP);
      mag5_2 <= mag1[4:0];
      qa3    <= qa;
      rem3   <= mag5_2 - qa9;
      qr4    <= qa3 + MW'(round_inc);
      if (zero4) begin
        mean5 <= MNW'(lmcc_pkg::ZERO_SUM_MEAN);
      end else begin
        mean5 <= neg4 ? -qr_s : qr_s;
      end
      if (centre_ext > mean5) begin
        cls6 <= lmcc_pkg::CODE_ABOVE;
      end else if (centre_ext == mean5) begin
        cls6 <= lmcc_pkg::CODE_EQUAL;
      end else begin
        cls6 <= lmcc_pkg::CODE_BELOW;
      end
      mean6    <= mean5[SAMPLE_BITS-1:0];
      up_right <= cls_mem[col5];

      class_valid   <= flags6.win;
      class_code    <= flags6.win ? cls6 : '0;
      local_mean    <= flags6.win ? mean6 : '0;
      cluster_valid <= flags6.clu;
      if (flags6.clu) begin
        cluster_code <= match ? cls6 : lmcc_pkg::CODE_NONE;
      end else begin
        cluster_code <= '0;
      end
      frame_end <= flags6.last;
      for (int k = 0; k < lmcc_pkg::TALLY_N; k++) begin
        count_q[k] <= flags6.last ? tally_next[k] : '0;
      end
    end
    if (ben && vld[STAGES] && flags6.win) begin
      cls_mem[col6] <= cls6;
    end
  end

  assign class_below_count   = count_q[0];
  assign class_equal_count   = count_q[1];
  assign class_above_count   = count_q[2];
  assign cluster_below_count = count_q[3];
  assign cluster_equal_count = count_q[4];
  assign cluster_above_count = count_q[5];

  `LMCC_ASSERT_NOW(a_cluster_has_class, result_valid && cluster_valid, class_valid, "cluster without class")
  `LMCC_ASSERT_NOW(a_end_has_class, result_valid && frame_end, class_valid, "frame end on border cell")
  `LMCC_ASSERT_NEXT(a_restart_clears, restart, tally[0] == '0 && tally[3] == '0, "tallies not cleared")

endmodule

// ----- src/local_mean_classify_cluster_top.sv -----
// Local mean classifier: takes grid samples in raster order and returns one result per
// sample, giving the class of the interior cell one row and one column back against its
// rounded 3x3 mean, the 2x2 cluster of the cell two rows and two columns back, and the
// frame tallies on the last sample. It sustains one sample per clock while results are not
// stalled. Each sample passes the window front (line store read, then column sum), the
// four-entry request queue and the back pipeline (divide by nine through a reciprocal
// multiply, rounding, sign, compare, cluster and tally). sample_stall rises only when the
// queue is full, which happens only after results have been stalled. A write to grid_rows
// or grid_cols restarts the frame at its first sample.
`timescale 1ns / 1ps

module local_mean_classify_cluster_top #(
  parameter int MAX_DIM     = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              class_valid,
  output logic [1:0]                        class_code,
  output logic signed [SAMPLE_BITS-1:0]     local_mean,
  output logic                              cluster_valid,
  output logic [1:0]                        cluster_code,
  output logic                              frame_end,
  output logic [lmcc_pkg::COUNT_W-1:0]      class_below_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      class_equal_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      class_above_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      cluster_below_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      cluster_equal_count,
  output logic [lmcc_pkg::COUNT_W-1:0]      cluster_above_count
);

  localparam int PW = $clog2(MAX_DIM);
  localparam int SW = SAMPLE_BITS + 4;
  localparam int FW = lmcc_pkg::FLAGS_W;
  localparam int QW = SW + SAMPLE_BITS + PW + FW;

  logic [6:0] grid_rows, grid_cols;
  logic       cfg_write;

  logic                          push, pop, full, empty;
  logic signed [SW-1:0]          win_sum;
  logic signed [SAMPLE_BITS-1:0] centre;
  logic [PW-1:0]                 col;
  lmcc_pkg::pos_flags_t          flags;
  logic [QW-1:0]                 q_wdata, q_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= lmcc_pkg::DIM_RESET;
      grid_cols <= lmcc_pkg::DIM_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        lmcc_pkg::REG_GRID_ROWS: grid_rows <= pwdata[6:0];
        lmcc_pkg::REG_GRID_COLS: grid_cols <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lmcc_pkg::REG_GRID_ROWS: prdata = {25'd0, grid_rows};
      lmcc_pkg::REG_GRID_COLS: prdata = {25'd0, grid_cols};
    endcase
  end

  lmcc_front #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_write),
    .grid_rows    (grid_rows),
    .grid_cols    (grid_cols),
    .sample_valid (sample_valid),
    .sample       (sample),
    .sample_stall (sample_stall),
    .full         (full),
    .push         (push),
    .win_sum      (win_sum),
    .centre       (centre),
    .col_out      (col),
    .flags_out    (flags)
  );

  assign q_wdata = {win_sum, centre, col, flags};

  lmcc_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (full),
    .empty (empty)
  );

  lmcc_back #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .restart             (cfg_write),
    .q_valid             (!empty),
    .q_sum               (q_rdata[QW-1 -: SW]),
    .q_centre            (q_rdata[SAMPLE_BITS+PW+FW-1 -: SAMPLE_BITS]),
    .q_col               (q_rdata[PW+FW-1 -: PW]),
    .q_flags             (lmcc_pkg::pos_flags_t'(q_rdata[FW-1:0])),
    .pop                 (pop),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .class_valid         (class_valid),
    .class_code          (class_code),
    .local_mean          (local_mean),
    .cluster_valid       (cluster_valid),
    .cluster_code        (cluster_code),
    .frame_end           (frame_end),
    .class_below_count   (class_below_count),
    .class_equal_count   (class_equal_count),
    .class_above_count   (class_above_count),
    .cluster_below_count (cluster_below_count),
    .cluster_equal_count (cluster_equal_count),
    .cluster_above_count (cluster_above_count)
  );

endmodule

// ----- test/lmcc_checker.sv -----
`timescale 1ns / 1ps

module lmcc_checker #(
  parameter int MAX_DIM     = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  input  logic [31:0]                       prdata,
  input  logic                              pready,
  input  logic                              sample_valid,
  input  logic                              sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic                              class_valid,
  input  logic [1:0]                        class_code,
  input  logic signed [SAMPLE_BITS-1:0]     local_mean,
  input  logic                              cluster_valid,
  input  logic [1:0]                        cluster_code,
  input  logic                              frame_end,
  input  logic [lmcc_pkg::COUNT_W-1:0]      class_below_count,
  input  logic [lmcc_pkg::COUNT_W-1:0]      class_equal_count,
  input  logic [lmcc_pkg::COUNT_W-1:0]      class_above_count,
  input  logic [lmcc_pkg::COUNT_W-1:0]      cluster_below_count,
  input  logic [lmcc_pkg::COUNT_W-1:0]      cluster_equal_count,
  input  logic [lmcc_pkg::COUNT_W-1:0]      cluster_above_count,
  output int                                outstanding,
  output int                                mismatches
);

  import lmcc_pkg::*;

  // Tally slots: class below, equal, above, then cluster below, equal, above.
  typedef struct packed {
    logic                             cls_v;
    logic [1:0]                       cls;
    logic [SAMPLE_BITS-1:0]           mean;
    logic                             clu_v;
    logic [1:0]                       clu;
    logic                             fend;
    logic [TALLY_N-1:0][COUNT_W-1:0]  tally;
  } cell_result_t;

  cell_result_t expected_q[$];

  logic [CFG_W-1:0]                rows_reg;
  logic [CFG_W-1:0]                cols_reg;
  logic signed [SAMPLE_BITS-1:0]   upper_line[MAX_DIM];
  logic signed [SAMPLE_BITS-1:0]   middle_line[MAX_DIM];
  logic signed [SAMPLE_BITS-1:0]   win[6];
  logic [1:0]                      class_line[MAX_DIM];
  logic [1:0]                      nb_upleft;
  logic [1:0]                      nb_left;
  logic [TALLY_N-1:0][COUNT_W-1:0] tally;
  int                              row_at;
  int                              col_at;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("lmcc_checker: %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic int grid_span(input logic [CFG_W-1:0] v);
    int n;
    n = int'(v);
    if (n < DIM_MIN) return DIM_MIN;
    if (n > MAX_DIM) return MAX_DIM;
    return n;
  endfunction

  // Nearest integer of total/9, halves away from zero; a window that sums to zero has a fixed mean.
  function automatic longint mean_of_nine(input longint total);
    longint mag;
    longint q;
    if (total == 0) return longint'(ZERO_SUM_MEAN);
    mag = (total < 0) ? -total : total;
    q = (2 * mag + WINDOW_CELLS) / (2 * WINDOW_CELLS);
    return (total < 0) ? -q : q;
  endfunction

  task automatic bump_tally(input int k);
    if (tally[k] != COUNT_MAX) tally[k] = tally[k] + 1'b1;
  endtask

  task automatic restart_grid();
    for (int k = 0; k < 6; k++) win[k] = '0;
    nb_upleft = '0;
    nb_left   = '0;
    tally     = '0;
    row_at    = 0;
    col_at    = 0;
  endtask

  task automatic clear_model();
    rows_reg = DIM_RESET;
    cols_reg = DIM_RESET;
    for (int k = 0; k < MAX_DIM; k++) begin
      upper_line[k]  = '0;
      middle_line[k] = '0;
      class_line[k]  = '0;
    end
    restart_grid();
  endtask

  task automatic predict_cell(input logic signed [SAMPLE_BITS-1:0] smp);
    int                            rows;
    int                            cols;
    int                            ci;
    longint                        total;
    longint                        centre;
    longint                        m;
    logic signed [SAMPLE_BITS-1:0] top_v;
    logic signed [SAMPLE_BITS-1:0] mid_v;
    logic [1:0]                    cur;
    logic [1:0]                    up_right;
    logic                          last_col;
    cell_result_t                  e;
    rows     = grid_span(rows_reg);
    cols     = grid_span(cols_reg);
    ci       = (col_at < MAX_DIM) ? col_at : MAX_DIM - 1;
    top_v    = upper_line[ci];
    mid_v    = middle_line[ci];
    last_col = (col_at >= cols - 1);
    e        = '0;
    if (row_at == 0 && col_at == 0) tally = '0;
    if (row_at >= 2 && col_at >= 2) begin
      total = longint'(top_v) + longint'(mid_v) + longint'(smp);
      for (int k = 0; k < 6; k++) total += longint'(win[k]);
      centre = longint'(win[3]);
      m      = mean_of_nine(total);
      cur    = (centre > m) ? CODE_ABOVE : ((centre == m) ? CODE_EQUAL : CODE_BELOW);
      e.cls_v = 1'b1;
      e.cls   = cur;
      e.mean  = m[SAMPLE_BITS-1:0];
      bump_tally(int'(cur));
      up_right = class_line[ci];
      // The cluster of the cell one row and one column further back is judged here.
      if (row_at >= 3 && col_at >= 3) begin
        e.clu_v = 1'b1;
        if (nb_upleft == cur && up_right == cur && nb_left == cur) begin
          e.clu = cur;
          bump_tally(3 + int'(cur));
        end else begin
          e.clu = CODE_NONE;
        end
      end
      nb_upleft      = up_right;
      nb_left        = cur;
      class_line[ci] = cur;
    end
    win[0] = win[1];
    win[1] = top_v;
    win[2] = win[3];
    win[3] = mid_v;
    win[4] = win[5];
    win[5] = smp;
    upper_line[ci]  = mid_v;
    middle_line[ci] = smp;
    if (last_col && row_at >= rows - 1) begin
      e.fend  = 1'b1;
      e.tally = tally;
    end
    if (last_col) begin
      col_at = 0;
      row_at = (row_at >= rows - 1) ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
    expected_q.push_back(e);
  endtask

  task automatic check_result();
    cell_result_t                    want;
    logic [TALLY_N-1:0][COUNT_W-1:0] seen;
    if (expected_q.size() == 0) begin
      report_mismatch("result with no sample waiting", 1, 0);
      return;
    end
    want = expected_q.pop_front();
    seen = {cluster_above_count, cluster_equal_count, cluster_below_count,
            class_above_count, class_equal_count, class_below_count};
    if (class_valid !== want.cls_v) report_mismatch("class_valid", class_valid, want.cls_v);
    if (class_code !== want.cls) report_mismatch("class_code", class_code, want.cls);
    if (local_mean !== want.mean) begin
      report_mismatch("local_mean", longint'(local_mean),
                      longint'($signed(want.mean)));
    end
    if (cluster_valid !== want.clu_v) begin
      report_mismatch("cluster_valid", cluster_valid, want.clu_v);
    end
    if (cluster_code !== want.clu) report_mismatch("cluster_code", cluster_code, want.clu);
    if (frame_end !== want.fend) report_mismatch("frame_end", frame_end, want.fend);
    for (int k = 0; k < TALLY_N; k++) begin
      if (seen[k] !== want.tally[k]) begin
        report_mismatch($sformatf("tally slot %0d", k), seen[k], want.tally[k]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      expected_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_GRID_ROWS) rows_reg = pwdata[CFG_W-1:0];
          else cols_reg = pwdata[CFG_W-1:0];
          restart_grid();
        end else if (prdata !== 32'((paddr[2] == REG_GRID_ROWS) ? rows_reg : cols_reg)) begin
          report_mismatch("register readback", prdata,
                          (paddr[2] == REG_GRID_ROWS) ? rows_reg : cols_reg);
        end
      end
      if (result_valid && !result_stall) check_result();
      if (sample_valid && !sample_stall) predict_cell(sample);
    end
    outstanding = expected_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  import lmcc_pkg::*;

  localparam int SW          = 24;
  localparam int HOLD_CYCLES = 80;
  localparam int ITEM_BUDGET = 1750;

  typedef enum int {FILL_WIDE, FILL_NARROW, FILL_FLAT, FILL_EDGE, FILL_MILD} fill_mode_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 sample_valid;
  logic                 sample_stall;
  logic signed [SW-1:0] sample;
  logic                 result_valid;
  logic                 result_stall;
  logic                 class_valid;
  logic [1:0]           class_code;
  logic signed [SW-1:0] local_mean;
  logic                 cluster_valid;
  logic [1:0]           cluster_code;
  logic                 frame_end;
  logic [COUNT_W-1:0]   class_below_count;
  logic [COUNT_W-1:0]   class_equal_count;
  logic [COUNT_W-1:0]   class_above_count;
  logic [COUNT_W-1:0]   cluster_below_count;
  logic [COUNT_W-1:0]   cluster_equal_count;
  logic [COUNT_W-1:0]   cluster_above_count;
  int                   outstanding;
  int                   mismatches;

  // Shared between the request side and the result side.
  bit calm;
  int holds_asked;

  always #5 clk = ~clk;

  local_mean_classify_cluster_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall),
    .class_valid(class_valid), .class_code(class_code), .local_mean(local_mean),
    .cluster_valid(cluster_valid), .cluster_code(cluster_code), .frame_end(frame_end),
    .class_below_count(class_below_count), .class_equal_count(class_equal_count),
    .class_above_count(class_above_count), .cluster_below_count(cluster_below_count),
    .cluster_equal_count(cluster_equal_count), .cluster_above_count(cluster_above_count)
  );

  lmcc_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall),
    .class_valid(class_valid), .class_code(class_code), .local_mean(local_mean),
    .cluster_valid(cluster_valid), .cluster_code(cluster_code), .frame_end(frame_end),
    .class_below_count(class_below_count), .class_equal_count(class_equal_count),
    .class_above_count(class_above_count), .cluster_below_count(cluster_below_count),
    .cluster_equal_count(cluster_equal_count), .cluster_above_count(cluster_above_count),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  initial begin
    #3_000_000;
    $display("tb_top: timed out with %0d results outstanding", outstanding);
    $display("tb_top: done, errors");
    $finish;
  end

  // Result side: random stalls unless calm, plus one long hold-off whenever the request side asks.
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != holds_asked) begin
        holds_seen = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= !calm && ($urandom_range(0, 99) < 16);
      end
    end
  end

  // Each task below is entered just after a rising edge and returns just after one,
  // having driven nothing in that last time step.
  task automatic send_sample(input logic [SW-1:0] v);
    sample_valid <= 1'b1;
    sample       <= v;
    do @(negedge clk); while (sample_stall);
    @(posedge clk);
  endtask

  task automatic idle_cycle();
    sample_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [6:0] rows_w, input logic [6:0] cols_w);
    logic [31:0] junk;
    // Bits above the register width are sometimes set; the block must drop them.
    junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_FF80) : 32'h0;
    apb_access(1'b1, REG_GRID_ROWS, junk | 32'(rows_w));
    apb_access(1'b1, REG_GRID_COLS, junk | 32'(cols_w));
    apb_access(1'b0, REG_GRID_ROWS, 32'h0);
    apb_access(1'b0, REG_GRID_COLS, 32'h0);
  endtask

  function automatic int span_of(input logic [6:0] v);
    if (v < 7'd3) return 3;
    if (v > 7'd64) return 64;
    return int'(v);
  endfunction

  function automatic logic [SW-1:0] pick_sample(input fill_mode_t mode,
                                                input logic [SW-1:0] level);
    case (mode)
      FILL_WIDE:   return SW'($urandom);
      FILL_NARROW: return SW'($urandom_range(0, 6) - 3);
      FILL_FLAT:   return level;
      FILL_EDGE: begin
        if ($urandom_range(0, 1) == 1) return 24'h7F_FFFF - SW'($urandom_range(0, 15));
        return 24'h80_0000 + SW'($urandom_range(0, 15));
      end
      default:     return SW'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  initial begin
    int          samples_sent;
    int          grids_set;
    int          frames_done;
    int          phase;
    int          frames;
    int          count;
    int          full_count;
    int          pause_at;
    logic [6:0]  rows_w;
    logic [6:0]  cols_w;
    fill_mode_t  mode;
    logic [SW-1:0] level;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    sample_valid <= 1'b0;
    sample       <= '0;
    calm         = 1'b0;
    holds_asked  = 0;
    samples_sent = 0;
    grids_set    = 0;
    frames_done  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers read back their reset value before anything is written.
    apb_access(1'b0, REG_GRID_ROWS, 32'h0);
    apb_access(1'b0, REG_GRID_COLS, 32'h0);

    // Smallest grid, extreme samples around a zero centre: its mean rounds to zero.
    set_grid(7'd3, 7'd3);
    grids_set++;
    send_sample(24'h7F_FFFF); send_sample(24'h80_0000); send_sample(24'h7F_FFFF);
    send_sample(24'h80_0000); send_sample(24'h00_0000); send_sample(24'h80_0000);
    send_sample(24'h7F_FFFF); send_sample(24'h80_0000); send_sample(24'h7F_FFFF);
    samples_sent += 9;
    frames_done++;

    // All-zero 4x4 grid: zero sums give the fixed negative mean and one all-above cluster.
    drain();
    set_grid(7'd4, 7'd4);
    grids_set++;
    for (int i = 0; i < 16; i++) send_sample('0);
    samples_sent += 16;
    frames_done++;

    phase = 0;
    while (samples_sent < ITEM_BUDGET) begin
      drain();
      case ($urandom_range(0, 19))
        0: begin rows_w = 7'($urandom_range(0, 2)); cols_w = 7'($urandom_range(3, 6)); end
        1: begin rows_w = 7'($urandom_range(64, 127)); cols_w = 7'($urandom_range(0, 4)); end
        2: begin rows_w = 7'($urandom_range(0, 4)); cols_w = 7'($urandom_range(64, 127)); end
        3: begin rows_w = 7'($urandom_range(3, 64)); cols_w = 7'd3; end
        default: begin
          rows_w = 7'($urandom_range(3, 8));
          cols_w = 7'($urandom_range(3, 8));
        end
      endcase
      if (phase == 2) begin
        rows_w = 7'd8;
        cols_w = 7'd8;
      end
      set_grid(rows_w, cols_w);
      grids_set++;
      // One phase fills the block against a long result hold-off; another runs without gaps.
      calm = (phase == 1) || (phase == 2);
      if (phase == 2) holds_asked++;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames && samples_sent < ITEM_BUDGET; f++) begin
        mode = fill_mode_t'($urandom_range(0, 4));
        case ($urandom_range(0, 2))
          0:       level = '0;
          1:       level = SW'($urandom_range(0, 6) - 3);
          default: level = SW'($urandom);
        endcase
        full_count = span_of(rows_w) * span_of(cols_w);
        count = full_count;
        if (f == frames - 1 && $urandom_range(0, 9) == 0) count = $urandom_range(1, count - 1);
        // The last frame of the run is cut short so the total stays near the budget.
        if (count > ITEM_BUDGET - samples_sent) count = ITEM_BUDGET - samples_sent;
        pause_at = ($urandom_range(0, 14) == 0) ? $urandom_range(1, count - 1) : -1;
        if (phase == 3) pause_at = count / 2;
        for (int i = 0; i < count; i++) begin
          if (i == pause_at) drain();
          while (!calm && $urandom_range(0, 99) < 16) idle_cycle();
          send_sample(pick_sample(mode, level));
          samples_sent++;
        end
        if (count == full_count) frames_done++;
      end
      phase++;
    end
    calm = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    $display("tb_top: %0d samples over %0d grid settings, %0d complete frames",
             samples_sent, grids_set, frames_done);
    $display("tb_top: sides clamped from both ends, cut-off frames, a long result hold-off");
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
